### sv/block_rms_normalize_assert.svh
// Assertion macros for the block RMS normalizer.
`ifndef BLOCK_RMS_NORMALIZE_ASSERT_SVH
`define BLOCK_RMS_NORMALIZE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define BRN_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("brn assertion failed");

// consequent holds in the same cycle as the antecedent
`define BRN_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brn assertion failed");

// consequent holds in the cycle after the antecedent
`define BRN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brn assertion failed");

`endif

### sv/brn_pkg.sv
// Shared types and constants of the block RMS normalizer.
package brn_pkg;

   localparam int DEGREE_W    = 3;
   localparam int FLOOR_W     = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int SUM_W       = 40;
   localparam int MEAN_SHIFT  = 16;
   localparam int MEAN_W      = SUM_W + MEAN_SHIFT;
   localparam int ROOT_W      = MEAN_W / 2;
   localparam int ROUND_SHIFT = 8;
   localparam int RMS_SHIFT   = 8;
   localparam int Q_ONE       = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RMS_FLOOR    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_LOAD,
      ST_MEAN,
      ST_SQLOAD,
      ST_SQRT,
      ST_CHECK,
      ST_READ,
      ST_MUL,
      ST_NUM,
      ST_DIV,
      ST_EMIT
   } brn_state_type;

endpackage

### sv/brn_req_if.sv
// Sample input channel of the block RMS normalizer.
interface brn_req_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                               valid;
   logic                               ready;
   logic signed [SAMPLE_WIDTH-1:0]     sample;
   logic signed [SAMPLE_WIDTH-1:0]     block_scale;
   logic [brn_pkg::DEGREE_W-1:0]       block_degree;

   modport source (output valid, sample, block_scale, block_degree, input ready);
   modport sink   (input valid, sample, block_scale, block_degree, output ready);
endinterface

### sv/brn_rsp_if.sv
// Normalized result channel of the block RMS normalizer.
interface brn_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_sample;
   logic                           last_of_block;
   logic                           zero_rms;

   modport source (output valid, out_sample, last_of_block, zero_rms, input ready);
   modport sink   (input valid, out_sample, last_of_block, zero_rms, output ready);
endinterface

### sv/block_rms_normalize.sv
// Block RMS normalizer top level: sample store, sum of squares, shared divider, sqrt.
// Non-final sample: store and square, then accumulate; the next sample waits until both are done.
// Final sample: 56-step mean divider, then 28-step root; then each result passes read, multiply,
// numerator load and the bit-serial divider; zero results go straight to emission.
// Results leave through an output register; the next block loads while the last one waits.
// Reset (synchronous): empties the block, clears the sum and control registers; datapath and store contents undefined.
`include "block_rms_normalize_assert.svh"

module block_rms_normalize #(
   parameter int MAX_DEGREE   = 7,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   brn_req_if.sink                            req_chan,
   brn_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [brn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [brn_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int DEPTH   = 2 * MAX_DEGREE + 1;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int SUM_W   = brn_pkg::SUM_W;
   localparam int MEAN_W  = brn_pkg::MEAN_W;
   localparam int ROOT_W  = brn_pkg::ROOT_W;
   localparam int NUM_W   = 2 * SW + brn_pkg::ROUND_SHIFT;
   localparam int DIV_N   = (NUM_W > MEAN_W) ? NUM_W : MEAN_W;
   localparam int STEP_W  = $clog2(DIV_N + 1);
   localparam logic [DIV_N-1:0] NEG_LIM = DIV_N'(1) << (SW - 1);
   localparam logic [SW-1:0]    UNITY   = SW'(brn_pkg::Q_ONE);

   function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] v);
      mag_of = v[SW-1] ? (~v + 1'b1) : v;
   endfunction

   // control
   brn_pkg::brn_state_type state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   end_ff, end_in;
   logic [CW-1:0]          d_ff, d_in;
   logic [AW-1:0]          k_ff, k_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   scale_enable_ff, scale_enable_in;
   logic [brn_pkg::FLOOR_W-1:0] rms_floor_ff, rms_floor_in;
   logic [SW-1:0]          held_scale_ff, held_scale_in;

   // datapath
   logic [2*SW-1:0]        sq_ff, sq_in;
   logic [DIV_N-1:0]       dv_num_ff, dv_num_in;
   logic [ROOT_W-1:0]      dv_rem_ff, dv_rem_in;
   logic [DIV_N-1:0]       dv_quo_ff, dv_quo_in;
   logic [ROOT_W-1:0]      dv_den_ff, dv_den_in;
   logic [MEAN_W-1:0]      sr_rad_ff, sr_rad_in;
   logic [ROOT_W:0]        sr_rem_ff, sr_rem_in;
   logic [ROOT_W-1:0]      sr_root_ff, sr_root_in;
   logic [ROOT_W-1:0]      q_ff, q_in;
   logic                   zero_ff, zero_in;
   logic [SW-1:0]          smag_ff, smag_in;
   logic                   sneg_ff, sneg_in;
   logic [2*SW-1:0]        prod_ff, prod_in;
   logic                   xneg_ff, xneg_in;
   logic [SW-1:0]          out_sample_ff, out_sample_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_zero_ff, out_zero_in;

   // element store
   logic [SW-1:0]          mem [DEPTH];
   logic [SW-1:0]          rd_data_ff;

   // combinational helpers
   logic                   req_fire;
   logic                   emit_go;
   logic                   last_k;
   int                     deg_c;
   logic [CW-1:0]          need;
   logic [CW-1:0]          count_inc;
   logic [SW-1:0]          xmag_in;
   logic [SW-1:0]          xmag_rd;
   logic [SW-1:0]          s_sel;
   logic [ROOT_W:0]        dv_sh;
   logic                   dv_ge;
   logic [ROOT_W:0]        dv_diff;
   logic [ROOT_W+2:0]      sr_sh;
   logic [ROOT_W+2:0]      sr_trial;
   logic                   sr_ge;
   logic [ROOT_W+2:0]      sr_diff;
   logic [NUM_W-1:0]       num_val;
   logic [SW-1:0]          sat_val;

   // assertion helpers
   logic [63:0]            chk_root;
   logic [63:0]            chk_mean;
   logic                   root_ok;
   logic                   block_clear;

   assign req_chan.ready         = (state_ff == brn_pkg::ST_IDLE);
   assign req_fire               = req_chan.valid && req_chan.ready;
   assign emit_go                = (state_ff == brn_pkg::ST_EMIT) &&
                                   (!rsp_valid_ff || rsp_chan.ready);
   assign last_k                 = (CW'(k_ff) == (d_ff - 1'b1));
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_sample    = out_sample_ff;
   assign rsp_chan.last_of_block = out_last_ff;
   assign rsp_chan.zero_rms      = out_zero_ff;

   always_comb begin
      deg_c     = (int'(req_chan.block_degree) > MAX_DEGREE) ?
                  MAX_DEGREE : int'(req_chan.block_degree);
      need      = CW'(2 * deg_c + 1);
      count_inc = count_ff + 1'b1;
      xmag_in   = mag_of(req_chan.sample);
      xmag_rd   = mag_of(rd_data_ff);
      s_sel     = scale_enable_ff ? held_scale_ff : UNITY;

      // restoring divider step
      dv_sh   = {dv_rem_ff, dv_num_ff[DIV_N-1]};
      dv_ge   = (dv_sh >= {1'b0, dv_den_ff});
      dv_diff = dv_sh - {1'b0, dv_den_ff};

      // digit-by-digit root step, two radicand bits per step
      sr_sh    = {sr_rem_ff, sr_rad_ff[MEAN_W-1 -: 2]};
      sr_trial = {1'b0, sr_root_ff, 2'b01};
      sr_ge    = (sr_sh >= sr_trial);
      sr_diff  = sr_sh - sr_trial;

      num_val = {prod_ff, {brn_pkg::ROUND_SHIFT{1'b0}}} + NUM_W'(q_ff >> 1);

      if (sneg_ff != xneg_ff) begin
         sat_val = (dv_quo_ff >= NEG_LIM) ? NEG_LIM[SW-1:0] : (~dv_quo_ff[SW-1:0] + 1'b1);
      end else begin
         sat_val = (dv_quo_ff >= NEG_LIM) ? ~NEG_LIM[SW-1:0] : dv_quo_ff[SW-1:0];
      end

      state_in        = state_ff;
      count_in        = count_ff;
      sum_in          = sum_ff;
      end_in          = end_ff;
      d_in            = d_ff;
      k_in            = k_ff;
      step_in         = step_ff;
      scale_enable_in = scale_enable_ff;
      rms_floor_in    = rms_floor_ff;
      held_scale_in   = held_scale_ff;
      sq_in           = sq_ff;
      dv_num_in       = dv_num_ff;
      dv_rem_in       = dv_rem_ff;
      dv_quo_in       = dv_quo_ff;
      dv_den_in       = dv_den_ff;
      sr_rad_in       = sr_rad_ff;
      sr_rem_in       = sr_rem_ff;
      sr_root_in      = sr_root_ff;
      q_in            = q_ff;
      zero_in         = zero_ff;
      smag_in         = smag_ff;
      sneg_in         = sneg_ff;
      prod_in         = prod_ff;
      xneg_in         = xneg_ff;
      out_sample_in   = out_sample_ff;
      out_last_in     = out_last_ff;
      out_zero_in     = out_zero_ff;
      rsp_valid_in    = rsp_chan.ready ? 1'b0 : rsp_valid_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            brn_pkg::CSR_SCALE_ENABLE: scale_enable_in = csr_write_data[0];
            brn_pkg::CSR_RMS_FLOOR:    rms_floor_in    = csr_write_data;
         endcase
      end

      unique case (state_ff)
         brn_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (count_ff == '0) begin
                  held_scale_in = req_chan.block_scale;
               end
               sq_in    = xmag_in * xmag_in;
               end_in   = (count_inc >= need);
               count_in = count_inc;
               state_in = brn_pkg::ST_ACC;
            end
         end
         brn_pkg::ST_ACC: begin
            sum_in   = sum_ff + SUM_W'(sq_ff);
            state_in = end_ff ? brn_pkg::ST_LOAD : brn_pkg::ST_IDLE;
         end
         brn_pkg::ST_LOAD: begin
            dv_num_in = DIV_N'({sum_ff, {brn_pkg::MEAN_SHIFT{1'b0}}}) << (DIV_N - MEAN_W);
            dv_rem_in = '0;
            dv_quo_in = '0;
            dv_den_in = ROOT_W'(count_ff);
            step_in   = STEP_W'(MEAN_W);
            d_in      = count_ff;
            count_in  = '0;
            sum_in    = '0;
            state_in  = brn_pkg::ST_MEAN;
         end
         brn_pkg::ST_MEAN: begin
            dv_rem_in = dv_ge ? dv_diff[ROOT_W-1:0] : dv_sh[ROOT_W-1:0];
            dv_quo_in = {dv_quo_ff[DIV_N-2:0], dv_ge};
            dv_num_in = dv_num_ff << 1;
            step_in   = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = brn_pkg::ST_SQLOAD;
            end
         end
         brn_pkg::ST_SQLOAD: begin
            sr_rad_in  = dv_quo_ff[MEAN_W-1:0];
            sr_rem_in  = '0;
            sr_root_in = '0;
            step_in    = STEP_W'(ROOT_W);
            state_in   = brn_pkg::ST_SQRT;
         end
         brn_pkg::ST_SQRT: begin
            sr_rem_in  = sr_ge ? sr_diff[ROOT_W:0] : sr_sh[ROOT_W:0];
            sr_root_in = {sr_root_ff[ROOT_W-2:0], sr_ge};
            sr_rad_in  = sr_rad_ff << 2;
            step_in    = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = brn_pkg::ST_CHECK;
            end
         end
         brn_pkg::ST_CHECK: begin
            q_in     = sr_root_ff;
            zero_in  = ((sr_root_ff >> brn_pkg::RMS_SHIFT) <= ROOT_W'(rms_floor_ff));
            smag_in  = mag_of(s_sel);
            sneg_in  = s_sel[SW-1];
            k_in     = '0;
            state_in = ((sr_root_ff >> brn_pkg::RMS_SHIFT) <= ROOT_W'(rms_floor_ff)) ?
                       brn_pkg::ST_EMIT : brn_pkg::ST_READ;
         end
         brn_pkg::ST_READ: begin
            state_in = brn_pkg::ST_MUL;
         end
         brn_pkg::ST_MUL: begin
            prod_in  = smag_ff * xmag_rd;
            xneg_in  = rd_data_ff[SW-1];
            state_in = brn_pkg::ST_NUM;
         end
         brn_pkg::ST_NUM: begin
            dv_num_in = DIV_N'(num_val) << (DIV_N - NUM_W);
            dv_rem_in = '0;
            dv_quo_in = '0;
            dv_den_in = q_ff;
            step_in   = STEP_W'(NUM_W);
            state_in  = brn_pkg::ST_DIV;
         end
         brn_pkg::ST_DIV: begin
            dv_rem_in = dv_ge ? dv_diff[ROOT_W-1:0] : dv_sh[ROOT_W-1:0];
            dv_quo_in = {dv_quo_ff[DIV_N-2:0], dv_ge};
            dv_num_in = dv_num_ff << 1;
            step_in   = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = brn_pkg::ST_EMIT;
            end
         end
         brn_pkg::ST_EMIT: begin
            if (emit_go) begin
               out_sample_in = zero_ff ? '0 : sat_val;
               out_last_in   = last_k;
               out_zero_in   = zero_ff;
               rsp_valid_in  = 1'b1;
               k_in          = k_ff + 1'b1;
               if (last_k) begin
                  state_in = brn_pkg::ST_IDLE;
               end else begin
                  state_in = zero_ff ? brn_pkg::ST_EMIT : brn_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = brn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= brn_pkg::ST_IDLE;
         count_ff        <= '0;
         sum_ff          <= '0;
         end_ff          <= 1'b0;
         d_ff            <= '0;
         k_ff            <= '0;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         scale_enable_ff <= 1'b1;
         rms_floor_ff    <= '0;
         held_scale_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         sum_ff          <= sum_in;
         end_ff          <= end_in;
         d_ff            <= d_in;
         k_ff            <= k_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
         scale_enable_ff <= scale_enable_in;
         rms_floor_ff    <= rms_floor_in;
         held_scale_ff   <= held_scale_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff         <= sq_in;
      dv_num_ff     <= dv_num_in;
      dv_rem_ff     <= dv_rem_in;
      dv_quo_ff     <= dv_quo_in;
      dv_den_ff     <= dv_den_in;
      sr_rad_ff     <= sr_rad_in;
      sr_rem_ff     <= sr_rem_in;
      sr_root_ff    <= sr_root_in;
      q_ff          <= q_in;
      zero_ff       <= zero_in;
      smag_ff       <= smag_in;
      sneg_ff       <= sneg_in;
      prod_ff       <= prod_in;
      xneg_ff       <= xneg_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
      out_zero_ff   <= out_zero_in;
   end

   // element store: written on accept, read registered during emission
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mem[count_ff[AW-1:0]] <= req_chan.sample;
      end
      rd_data_ff <= mem[k_ff];
   end

   assign chk_root    = 64'(sr_root_ff);
   assign chk_mean    = 64'(dv_quo_ff[MEAN_W-1:0]);
   assign root_ok     = (chk_root * chk_root <= chk_mean) &&
                        ((chk_root + 64'd1) * (chk_root + 64'd1) > chk_mean);
   assign block_clear = (state_ff == brn_pkg::ST_IDLE) && (count_ff == '0) && (sum_ff == '0);

   `BRN_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(DEPTH))
   `BRN_ASSERT_IMPL(a_root_floor, clock, reset, state_ff == brn_pkg::ST_CHECK, root_ok)
   `BRN_ASSERT_IMPL(a_zero_out, clock, reset, rsp_valid_ff && out_zero_ff, out_sample_ff == '0)
   `BRN_ASSERT_NEXT(a_block_done, clock, reset, emit_go && last_k, block_clear)

endmodule

### tb/tb_top.sv
// Self-checking testbench for the block RMS normalizer: directed and random blocks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W     = 16;
   localparam int IDLE_PCT     = 32;
   localparam int RANDOM_ITEMS = 250;
   localparam int STALL_LIMIT  = 3000;
   localparam int SETTLE_WAIT  = 16;
   localparam int DRAIN_WAIT   = 200;
   localparam int PRINT_LIMIT  = 30;

   typedef struct packed {
      logic [SAMPLE_W-1:0] out_sample;
      logic                last_of_block;
      logic                zero_rms;
   } norm_result_type;

   logic clock;
   logic reset;
   logic                           csr_write_enable;
   logic [brn_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [brn_pkg::CSR_DATA_W-1:0] csr_write_data;

   brn_req_if #(.SAMPLE_WIDTH(SAMPLE_W)) req_if ();
   brn_rsp_if #(.SAMPLE_WIDTH(SAMPLE_W)) rsp_if ();

   block_rms_normalize #(
      .MAX_DEGREE(7),
      .SAMPLE_WIDTH(SAMPLE_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor state
   logic [SAMPLE_W-1:0] blk_store [15];
   logic [39:0]         sq_sum;
   logic [3:0]          blk_count;
   logic [SAMPLE_W-1:0] held_scale_m;
   logic                cfg_scale_en;
   logic [15:0]         cfg_floor;

   norm_result_type expected_results [$];

   int  error_count;
   int  items_sent;
   int  blocks_done;
   int  zero_blocks;
   int  results_checked;
   int  stall_cycles;
   bit  steady;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [16:0] magnitude(input logic [SAMPLE_W-1:0] v);
      return v[SAMPLE_W-1] ? 17'h10000 - {1'b0, v} : {1'b0, v};
   endfunction

   // accumulate one sample; at block end push the normalized block
   function automatic void normalize_sample(input logic [SAMPLE_W-1:0] x,
                                            input logic [SAMPLE_W-1:0] sc,
                                            input logic [2:0] deg);
      int                  need;
      int                  d;
      logic [16:0]         xm;
      logic [63:0]         mean;
      logic [63:0]         root;
      logic [63:0]         trial;
      logic [63:0]         smag;
      logic [63:0]         num;
      logic [63:0]         y;
      logic [SAMPLE_W-1:0] scale_val;
      logic [SAMPLE_W-1:0] res;
      logic                zero;
      logic                neg;
      norm_result_type     item;

      need = 2 * deg + 1;
      if (blk_count == 0) held_scale_m = sc;
      blk_store[blk_count] = x;
      xm = magnitude(x);
      sq_sum = sq_sum + xm * xm;
      blk_count++;
      if (int'(blk_count) < need) return;

      d = blk_count;
      mean = ({24'b0, sq_sum} << 16) / d;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= mean) root = trial;
      end
      zero = ((root >> brn_pkg::RMS_SHIFT) <= {48'b0, cfg_floor}) || (root == 0);
      scale_val = cfg_scale_en ? held_scale_m : SAMPLE_W'(brn_pkg::Q_ONE);
      smag = magnitude(scale_val);

      for (int k = 0; k < d; k++) begin
         res = '0;
         if (!zero) begin
            num = (smag * magnitude(blk_store[k])) << brn_pkg::ROUND_SHIFT;
            y = (num + (root >> 1)) / root;
            neg = scale_val[SAMPLE_W-1] ^ blk_store[k][SAMPLE_W-1];
            if (neg)
               res = (y >= 64'd32768) ? 16'h8000 : 16'(64'd0 - y);
            else
               res = (y > 64'd32767) ? 16'h7FFF : y[15:0];
         end
         item.out_sample    = res;
         item.last_of_block = (k == d - 1);
         item.zero_rms      = zero;
         expected_results.push_back(item);
      end
      blocks_done++;
      if (zero) zero_blocks++;
      sq_sum = '0;
      blk_count = '0;
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] sc,
                              input logic [2:0] deg);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.sample       <= x;
      req_if.block_scale  <= sc;
      req_if.block_degree <= deg;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      normalize_sample(x, sc, deg);
      items_sent++;
   endtask

   // drop valid, let all pending results drain, then rest a little
   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_config(input logic se, input logic [15:0] fl);
      csr_write_enable <= 1'b1;
      csr_index        <= brn_pkg::CSR_SCALE_ENABLE;
      csr_write_data   <= {15'($urandom), se};
      @(posedge clock);
      cfg_scale_en = se;
      csr_index      <= brn_pkg::CSR_RMS_FLOOR;
      csr_write_data <= fl;
      @(posedge clock);
      cfg_floor = fl;
      csr_write_enable <= 1'b0;
   endtask

   // result side: check each transaction, then pick next ready
   initial begin
      norm_result_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               flag_error($sformatf("unexpected result %0d", $signed(rsp_if.out_sample)));
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.out_sample !== want.out_sample)
                  flag_error($sformatf("out_sample got %0d want %0d",
                                       $signed(rsp_if.out_sample), $signed(want.out_sample)));
               if (rsp_if.last_of_block !== want.last_of_block)
                  flag_error($sformatf("last_of_block got %b want %b",
                                       rsp_if.last_of_block, want.last_of_block));
               if (rsp_if.zero_rms !== want.zero_rms)
                  flag_error($sformatf("zero_rms got %b want %b",
                                       rsp_if.zero_rms, want.zero_rms));
            end
         end
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_write_enable)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic test_extremes();
      send_sample(16'sd32767, 16'sd32767, 3'd0);
      send_sample(-16'sd32768, -16'sd32768, 3'd0);
      send_sample(16'sd32767, -16'sd1, 3'd1);
      send_sample(-16'sd32768, 16'sd0, 3'd1);
      send_sample(16'sd1, 16'sd0, 3'd1);
   endtask

   task automatic test_zero_block();
      repeat (3) send_sample(16'sd0, 16'sd4096, 3'd1);
   endtask

   // degree drops mid-block, so the block closes early with d = 4
   task automatic test_degree_change();
      send_sample(16'sd1000, 16'sd4096, 3'd2);
      send_sample(-16'sd2000, 16'sd4096, 3'd2);
      send_sample(16'sd3000, 16'sd4096, 3'd2);
      send_sample(-16'sd4000, 16'sd4096, 3'd0);
   endtask

   // only the first transaction's scale counts
   task automatic test_scale_sampling();
      send_sample(16'sd2048, 16'sd8192, 3'd1);
      send_sample(-16'sd512, -16'sd4096, 3'd1);
      send_sample(16'sd777, 16'sd0, 3'd1);
   endtask

   task automatic test_unity_scale();
      settle();
      set_config(1'b0, 16'd0);
      send_sample(16'sd12345, -16'sd7, 3'd0);
   endtask

   // rms of exactly 1.0 against a floor on and just below it
   task automatic test_rms_floor();
      settle();
      set_config(1'b1, 16'd4096);
      send_sample(16'sd4096, 16'sd5000, 3'd0);
      settle();
      set_config(1'b1, 16'd4095);
      send_sample(16'sd4096, 16'sd5000, 3'd0);
   endtask

   task automatic test_random_blocks();
      int          phase;
      int          goal;
      int          phase_end;
      int          kind;
      int          cls;
      logic        se;
      logic [15:0] fl;
      logic [2:0]  deg;
      logic [15:0] x;
      logic [15:0] sc;

      phase = 0;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         case (phase % 6)
            0: begin se = 1'b1; fl = 16'd0; end
            1: begin se = 1'b0; fl = 16'd0; end
            2: begin se = 1'b1; fl = 16'hFFFF; end
            3: begin se = 1'b1; fl = 16'($urandom_range(0, 4095)); end
            4: begin se = 1'b0; fl = 16'($urandom_range(0, 2047)); end
            default: begin se = 1'b1; fl = 16'($urandom_range(0, 65535)); end
         endcase
         settle();
         set_config(se, fl);
         steady = (phase == 3);
         phase_end = items_sent + 40;
         while (items_sent < phase_end) begin
            kind = $urandom_range(0, 99);
            cls  = $urandom_range(0, 99);
            deg  = 3'($urandom_range(0, 7));
            do begin
               if (kind >= 70 && kind < 80) deg = 3'($urandom_range(0, 7));
               if (kind >= 80 && kind < 88)
                  x = 16'd0;
               else if (cls < 50)
                  x = 16'($urandom);
               else if (cls < 75)
                  x = 16'($urandom_range(0, 600) - 300);
               else if (cls < 90)
                  x = 16'($urandom_range(0, 32) - 16);
               else
                  case ($urandom_range(0, 4))
                     0: x = 16'h7FFF;
                     1: x = 16'h8000;
                     2: x = 16'h0001;
                     3: x = 16'hFFFF;
                     default: x = 16'h0000;
                  endcase
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: sc = 16'($urandom);
                  5, 6, 7: sc = 16'(brn_pkg::Q_ONE + $urandom_range(0, 2048) - 1024);
                  8: sc = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
                  default: sc = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'(-brn_pkg::Q_ONE);
               endcase
               send_sample(x, sc, deg);
            end while (blk_count != 0);
         end
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      error_count     = 0;
      items_sent      = 0;
      blocks_done     = 0;
      zero_blocks     = 0;
      results_checked = 0;
      stall_cycles    = 0;
      steady          = 1'b0;
      sq_sum          = '0;
      blk_count       = '0;
      held_scale_m    = '0;
      cfg_scale_en    = 1'b1;
      cfg_floor       = '0;

      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.sample       <= '0;
      req_if.block_scale  <= '0;
      req_if.block_degree <= '0;
      csr_write_enable    <= 1'b0;
      csr_index           <= brn_pkg::CSR_SCALE_ENABLE;
      csr_write_data      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_config(1'b1, 16'd0);
      test_extremes();
      test_zero_block();
      test_degree_change();
      test_scale_sampling();
      test_unity_scale();
      test_rms_floor();
      test_random_blocks();

      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d samples in %0d blocks (%0d below the rms floor).",
               items_sent, blocks_done, zero_blocks);
      $display("Checked %0d normalized results across scale on/off and floor settings.",
               results_checked);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
